@@ rtl/smpq_pkg.sv @@
// ----------------------------------------------------------------------------
// smpq_pkg: shared types and constants for the stable max priority queue
// Field widths, status and mode codes, and the controller command word.
// ----------------------------------------------------------------------------
`default_nettype none

package smpq_pkg;

  // default number of queue entries
  localparam int QUEUE_DEPTH_DEF = 16;

  // field widths
  localparam int MODE_W   = 1;
  localparam int TAG_W    = 16;
  localparam int KEY_W    = 10;
  localparam int STATUS_W = 2;
  localparam int WAIT_W   = 5;

  // largest key, 10.00 in hundredths
  localparam logic [KEY_W-1:0] KEY_MAX = 10'd1000;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_ENQ = 1'b0;
  localparam logic [MODE_W-1:0] MODE_DEQ = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DEQUEUED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic commit;   // update the queue and load the result word
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/stable_max_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// stable_max_priority_queue_top: bounded max priority queue by grade average
// Sorted cell row under a two-state controller; equal keys keep arrival order.
// ----------------------------------------------------------------------------
// Result word: the accepted word is latched in the request register, then
//   committed to the result register; the input stays closed until that commit,
//   and the commit waits while a stalled result still occupies the output register.
// Every operation finishes within its commit since all cells compare in parallel.
// Reset: synchronous, active low; empties the queue and drops any pending result.
`default_nettype none

module stable_max_priority_queue_top #(
  parameter int QUEUE_DEPTH = smpq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [smpq_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [smpq_pkg::TAG_W-1:0]      in_student_tag,
  input  wire logic [smpq_pkg::KEY_W-1:0]      in_average,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [smpq_pkg::STATUS_W-1:0]   out_status,
  output logic      [smpq_pkg::TAG_W-1:0]      out_student_tag_res,
  output logic      [smpq_pkg::KEY_W-1:0]      out_average_res,
  output logic      [smpq_pkg::WAIT_W-1:0]     out_waiting_count
);

  smpq_pkg::cmd_t cmd;

  // controller
  smpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath
  smpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_mode             (in_mode),
    .in_student_tag      (in_student_tag),
    .in_average          (in_average),
    .out_status          (out_status),
    .out_student_tag_res (out_student_tag_res),
    .out_average_res     (out_average_res),
    .out_waiting_count   (out_waiting_count)
  );

endmodule

`default_nettype wire

@@ rtl/smpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// smpq_ctrl: sequencing controller
// Two-state machine that takes one word, then commits it once the result
// register is free. Owns the handshake flags of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  output smpq_pkg::cmd_t    cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  // result register can take a new word
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.commit  = (state_r == S_EXEC) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.commit) out_valid_nxt = 1'b1;
    else if (!out_stall)     out_valid_nxt = 1'b0;
    else                     out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/smpq_dp.sv @@
// ----------------------------------------------------------------------------
// smpq_dp: queue datapath
// Row of sorted cells. Every cell compares its key with the new key at once,
// so an insert or a head removal completes within its commit.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_dp #(
  parameter int QUEUE_DEPTH = smpq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire smpq_pkg::cmd_t                  cmd,
  input  wire logic [smpq_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [smpq_pkg::TAG_W-1:0]      in_student_tag,
  input  wire logic [smpq_pkg::KEY_W-1:0]      in_average,
  output logic      [smpq_pkg::STATUS_W-1:0]   out_status,
  output logic      [smpq_pkg::TAG_W-1:0]      out_student_tag_res,
  output logic      [smpq_pkg::KEY_W-1:0]      out_average_res,
  output logic      [smpq_pkg::WAIT_W-1:0]     out_waiting_count
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // latched request
  logic [smpq_pkg::MODE_W-1:0] mode_r;
  logic [smpq_pkg::TAG_W-1:0]  tag_r;
  logic [smpq_pkg::KEY_W-1:0]  key_r;

  // cells and fill count
  logic [smpq_pkg::KEY_W-1:0] cell_key_r [QUEUE_DEPTH];
  logic [smpq_pkg::TAG_W-1:0] cell_tag_r [QUEUE_DEPTH];
  logic [smpq_pkg::KEY_W-1:0] cell_key_nxt [QUEUE_DEPTH];
  logic [smpq_pkg::TAG_W-1:0] cell_tag_nxt [QUEUE_DEPTH];
  logic [CW-1:0]              count_r, count_nxt;
  logic [QUEUE_DEPTH-1:0]     ge;

  // result word
  logic [smpq_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [smpq_pkg::TAG_W-1:0]    res_tag_r, res_tag_nxt;
  logic [smpq_pkg::KEY_W-1:0]    res_key_r, res_key_nxt;
  logic [smpq_pkg::WAIT_W-1:0]   wait_r;

  logic empty, full, do_enq, do_deq;

  assign empty  = (count_r == '0);
  assign full   = (count_r == CW'(QUEUE_DEPTH));
  assign do_enq = (mode_r == smpq_pkg::MODE_ENQ) && !full;
  assign do_deq = (mode_r == smpq_pkg::MODE_DEQ) && !empty;

  // request capture, key saturates at 10.00
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      tag_r  <= in_student_tag;
      key_r  <= (in_average > smpq_pkg::KEY_MAX) ? smpq_pkg::KEY_MAX : in_average;
    end
  end

  // per-cell compare: occupied cell keeps its place when key >= new key
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge[i] = (CW'(i) < count_r) && (cell_key_r[i] >= key_r);
    end
  end

  // per-cell next value
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_key_nxt[i] = cell_key_r[i];
      cell_tag_nxt[i] = cell_tag_r[i];
      if (do_deq) begin
        if (i < QUEUE_DEPTH - 1) begin
          cell_key_nxt[i] = cell_key_r[(i + 1) % QUEUE_DEPTH];
          cell_tag_nxt[i] = cell_tag_r[(i + 1) % QUEUE_DEPTH];
        end
      end else if (do_enq && !ge[i]) begin
        if (i == 0 || ge[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH]) begin
          cell_key_nxt[i] = key_r;
          cell_tag_nxt[i] = tag_r;
        end else begin
          cell_key_nxt[i] = cell_key_r[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
          cell_tag_nxt[i] = cell_tag_r[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
        end
      end
    end
  end

  // count and result word
  always_comb begin
    count_nxt   = count_r;
    res_tag_nxt = '0;
    res_key_nxt = '0;
    priority if (mode_r == smpq_pkg::MODE_DEQ && empty) begin
      status_nxt = smpq_pkg::ST_EMPTY;
    end else if (mode_r == smpq_pkg::MODE_DEQ) begin
      status_nxt  = smpq_pkg::ST_DEQUEUED;
      res_tag_nxt = cell_tag_r[0];
      res_key_nxt = cell_key_r[0];
      count_nxt   = count_r - CW'(1);
    end else if (full) begin
      status_nxt = smpq_pkg::ST_FULL;
    end else begin
      status_nxt = smpq_pkg::ST_ENQUEUED;
      count_nxt  = count_r + CW'(1);
    end
  end

  // cell storage, no reset: only occupied cells are ever read
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        cell_key_r[i] <= cell_key_nxt[i];
        cell_tag_r[i] <= cell_tag_nxt[i];
      end
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r  <= status_nxt;
      res_tag_r <= res_tag_nxt;
      res_key_r <= res_key_nxt;
      wait_r    <= smpq_pkg::WAIT_W'(count_nxt);
    end
  end

  assign out_status          = status_r;
  assign out_student_tag_res = res_tag_r;
  assign out_average_res     = res_key_r;
  assign out_waiting_count   = wait_r;

endmodule

`default_nettype wire

@@ rtl/smpq_checker.sv @@
// ----------------------------------------------------------------------------
// smpq_checker: port-level checks for the priority queue
// Watches the top level's ports only; attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [smpq_pkg::STATUS_W-1:0]   out_status,
  input wire logic [smpq_pkg::TAG_W-1:0]      out_student_tag_res,
  input wire logic [smpq_pkg::KEY_W-1:0]      out_average_res,
  input wire logic [smpq_pkg::WAIT_W-1:0]     out_waiting_count
);

  // one word in flight: input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a word is in flight");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)
      && $stable(out_student_tag_res) && $stable(out_average_res)
      && $stable(out_waiting_count)))
    else $error("stalled result word changed");

  // only a dequeue carries a tag and key
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != smpq_pkg::ST_DEQUEUED)
      |-> (out_student_tag_res == '0 && out_average_res == '0))
    else $error("non-dequeue result carries payload");

  // empty status reports no waiting entries
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == smpq_pkg::ST_EMPTY) |-> (out_waiting_count == '0))
    else $error("empty status with nonzero count");

  // returned keys stay within 0 to 10.00
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_average_res <= smpq_pkg::KEY_MAX))
    else $error("returned key out of range");

endmodule

bind stable_max_priority_queue_top smpq_checker u_smpq_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_status          (out_status),
  .out_student_tag_res (out_student_tag_res),
  .out_average_res     (out_average_res),
  .out_waiting_count   (out_waiting_count)
);

`default_nettype wire
